// File: rtl/fnpc_pkg.sv
// ----------------------------------------------------------------------------
// fnpc_pkg: shared definitions for the four-neighbour peak clipper
// Port widths, register map, reset values and the structures passed between
// the front end, the request queue and the back end.
// ----------------------------------------------------------------------------
package fnpc_pkg;

   // Widths fixed by the external interface.
   localparam int PIXEL_PORT_W = 16;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // Register reset values.
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1;

   // Queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Pixel slots carried with each queued request.
   localparam int SLOT_PX    = 0;  // the incoming pixel, (r, c)
   localparam int SLOT_A     = 1;  // pending row, (r-1, c)
   localparam int SLOT_B     = 2;  // pending row, (r-1, c+1)
   localparam int SLOT_U     = 3;  // row above the pending row, (r-2, c)
   localparam int SLOT_UL    = 4;  // pending row, (r-1, c-1)
   localparam int SLOT_ML    = 5;  // current row, (r, c-1)
   localparam int SLOT_MLL   = 6;  // current row, (r, c-2)
   localparam int SLOT_COUNT = 7;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } fnpc_csr_index_type;

   typedef enum logic [1:0] {
      KIND_ABOVE,
      KIND_LEFT,
      KIND_FINAL
   } fnpc_kind_type;

   typedef struct packed {
      logic [WIDTH_REG_W-1:0]  width;
      logic [HEIGHT_REG_W-1:0] height;
      logic                    restart;
   } fnpc_cfg_type;

   typedef struct packed {
      logic has_above;  // pixel (r-1, c) is released
      logic has_left;   // pixel (last, c-1) is released
      logic has_final;  // pixel (last, last) is released
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic has_right;  // column c+1 lies inside the frame
   } fnpc_flags_type;

endpackage

// File: rtl/fnpc_csr.sv
// ----------------------------------------------------------------------------
// fnpc_csr: configuration registers
// Holds the frame width and height and flags a frame restart on any write.
// ----------------------------------------------------------------------------
module fnpc_csr
   import fnpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output fnpc_cfg_type          cfg
);

   logic                    width_ff;
   logic [WIDTH_REG_W-1:0]  frame_width_ff;
   logic [HEIGHT_REG_W-1:0] frame_height_ff;
   logic                    write_en;
   fnpc_csr_index_type      index;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign index    = fnpc_csr_index_type'(paddr[CSR_ADDR_W-1]);

   // Registers are word aligned, so the top address bit selects one.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (write_en) begin
         unique case (index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= pwdata[WIDTH_REG_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= pwdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // A spare flag keeps the write strobe visible for one cycle in debug.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 1'b0;
      end else begin
         width_ff <= write_en;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         CSR_FRAME_WIDTH:  prdata = CSR_DATA_W'(frame_width_ff);
         CSR_FRAME_HEIGHT: prdata = CSR_DATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // Any write restarts the frame at the same clock edge.
   always_comb begin
      cfg.width   = frame_width_ff;
      cfg.height  = frame_height_ff;
      cfg.restart = write_en && !width_ff ? 1'b1 : write_en;
   end

endmodule

// File: rtl/fnpc_front.sv
// ----------------------------------------------------------------------------
// fnpc_front: request intake and classification
// Tracks the raster position, reads the line store, gathers the neighbour
// pixels of each request and queues those that release results.
// ----------------------------------------------------------------------------
module fnpc_front
   import fnpc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  fnpc_cfg_type                   cfg,
   input  logic                           push,
   output logic                           full,
   input  logic [PIXEL_PORT_W-1:0]        pixel_in,
   input  logic [QCOUNT_W-1:0]            q_count,
   output logic                           q_push,
   output fnpc_flags_type                 q_flags,
   output logic [SLOT_COUNT*PIXEL_BITS-1:0] q_pix
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int PB = PIXEL_BITS;

   // Line store: upper half is the row above the pending row, lower half the
   // pending row. Data read from an entry before this frame wrote it is never used.
   logic [2*PB-1:0] line_mem_ff [MAX_WIDTH];

   logic [CW-1:0]           col_ff, col_in;
   logic [HEIGHT_REG_W-1:0] row_ff, row_in;
   logic [CW-1:0]           last_col;
   logic [HEIGHT_REG_W-1:0] last_row;
   logic [CW-1:0]           nxt_addr;
   logic                    at_last_col, at_last_row;
   logic                    accept, room;
   fnpc_flags_type          flags_in;

   logic                    s1_valid_ff;
   logic [PB-1:0]           s1_px_ff;
   logic [CW-1:0]           s1_col_ff;
   fnpc_flags_type          s1_flags_ff;
   logic                    s1_fwd_cur_ff, s1_fwd_nxt_ff;
   logic [2*PB-1:0]         rd_cur_ff;
   logic [PB-1:0]           rd_nxt_ff;

   logic [PB-1:0]           prev_a_ff, prev_px_ff, prev2_px_ff;
   logic [PB-1:0]           cur_a, cur_u, nxt_b;

   // Effective frame size from the raw register values.
   always_comb begin
      if (cfg.width == '0) begin
         last_col = '0;
      end else if (32'(cfg.width) > MAX_WIDTH) begin
         last_col = CW'(MAX_WIDTH - 1);
      end else begin
         last_col = CW'(cfg.width - 11'd1);
      end
      last_row = (cfg.height == '0) ? '0 : cfg.height - 16'd1;
   end

   assign at_last_col = (col_ff == last_col);
   assign at_last_row = (row_ff == last_row);

   // Room for the request in flight and for this one.
   assign room   = (32'(q_count) + 32'(s1_valid_ff)) < QUEUE_DEPTH;
   assign full   = !room;
   assign accept = push && room;

   assign nxt_addr = at_last_col ? col_ff : col_ff + 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      flags_in.has_above = (row_ff != '0);
      flags_in.has_left  = at_last_row && (col_ff != '0);
      flags_in.has_final = at_last_row && at_last_col;
      flags_in.row_ge2   = (row_ff > HEIGHT_REG_W'(1));
      flags_in.col_ge1   = (col_ff != '0);
      flags_in.col_ge2   = (col_ff > CW'(1));
      flags_in.has_right = !at_last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   // Stage one: capture the request and issue both line store reads. A read
   // of the entry being written in the same cycle takes the written data.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff      <= PB'(pixel_in);
         s1_col_ff     <= col_ff;
         s1_flags_ff   <= flags_in;
         s1_fwd_cur_ff <= s1_valid_ff && (s1_col_ff == col_ff);
         s1_fwd_nxt_ff <= s1_valid_ff && (s1_col_ff == nxt_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_cur_ff <= line_mem_ff[col_ff];
         rd_nxt_ff <= line_mem_ff[nxt_addr][PB-1:0];
      end
      if (s1_valid_ff) begin
         line_mem_ff[s1_col_ff] <= {cur_a, s1_px_ff};
      end
   end

   // Stage two: resolve the read data and queue the request.
   assign cur_a = s1_fwd_cur_ff ? prev_px_ff : rd_cur_ff[PB-1:0];
   assign cur_u = s1_fwd_cur_ff ? prev_a_ff  : rd_cur_ff[2*PB-1:PB];
   assign nxt_b = s1_fwd_nxt_ff ? prev_px_ff : rd_nxt_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         prev_a_ff   <= cur_a;
         prev_px_ff  <= s1_px_ff;
         prev2_px_ff <= prev_px_ff;
      end
   end

   assign q_push  = s1_valid_ff && (s1_flags_ff.has_above || s1_flags_ff.has_left ||
                                    s1_flags_ff.has_final);
   assign q_flags = s1_flags_ff;

   always_comb begin
      q_pix = '0;
      q_pix[SLOT_PX*PB  +: PB] = s1_px_ff;
      q_pix[SLOT_A*PB   +: PB] = cur_a;
      q_pix[SLOT_B*PB   +: PB] = nxt_b;
      q_pix[SLOT_U*PB   +: PB] = cur_u;
      q_pix[SLOT_UL*PB  +: PB] = prev_a_ff;
      q_pix[SLOT_ML*PB  +: PB] = prev_px_ff;
      q_pix[SLOT_MLL*PB +: PB] = prev2_px_ff;
   end

endmodule

// File: rtl/fnpc_queue.sv
// ----------------------------------------------------------------------------
// fnpc_queue: request queue between front end and back end
// Small first-in first-out buffer with the oldest entry shown at the head.
// ----------------------------------------------------------------------------
module fnpc_queue
   import fnpc_pkg::*;
#(
   parameter int WIDTH = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   output logic                head_valid,
   output logic [WIDTH-1:0]    head_data,
   output logic [QCOUNT_W-1:0] count
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// File: rtl/fnpc_back.sv
// ----------------------------------------------------------------------------
// fnpc_back: result sequencer
// Walks through the results released by the queued request, clips each one
// against its neighbours and holds it in the output register.
// ----------------------------------------------------------------------------
module fnpc_back
   import fnpc_pkg::*;
#(
   parameter int PIXEL_BITS = 16
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  fnpc_flags_type                   head_flags,
   input  logic [SLOT_COUNT*PIXEL_BITS-1:0] head_pix,
   output logic                             q_pop,
   input  logic                             pop,
   output logic                             empty,
   output logic [PIXEL_PORT_W-1:0]          pixel_out,
   output logic                             last_in_run,
   output logic                             end_of_frame
);

   localparam int PB = PIXEL_BITS;

   // Neighbour order: up, left, down, right.
   function automatic logic [PB-1:0] clip_peak(input logic [PB-1:0]   self,
                                               input logic [3:0]      has,
                                               input logic [4*PB-1:0] nb);
      logic [PB-1:0] best;
      logic          any;
      best = '0;
      any  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (has[i]) begin
            any = 1'b1;
            if (nb[i*PB +: PB] > best) begin
               best = nb[i*PB +: PB];
            end
         end
      end
      return (any && (self > best)) ? best : self;
   endfunction

   logic [1:0]          done_ff;
   logic [1:0]          done_set;
   logic                out_valid_ff;
   logic [PIXEL_PORT_W-1:0] pixel_ff;
   logic                last_ff, eof_ff;

   fnpc_kind_type       kind;
   logic                pend_above, pend_left;
   logic                is_last, load;
   logic [PB-1:0]       self_px, clipped;
   logic [3:0]          has_nb;
   logic [4*PB-1:0]     nb_px;
   logic [PB-1:0]       px, pa, pb, pu, pul, pml, pmll;

   assign px   = head_pix[SLOT_PX*PB  +: PB];
   assign pa   = head_pix[SLOT_A*PB   +: PB];
   assign pb   = head_pix[SLOT_B*PB   +: PB];
   assign pu   = head_pix[SLOT_U*PB   +: PB];
   assign pul  = head_pix[SLOT_UL*PB  +: PB];
   assign pml  = head_pix[SLOT_ML*PB  +: PB];
   assign pmll = head_pix[SLOT_MLL*PB +: PB];

   assign pend_above = head_flags.has_above && !done_ff[0];
   assign pend_left  = head_flags.has_left  && !done_ff[1];

   always_comb begin
      priority if (pend_above) begin
         kind = KIND_ABOVE;
      end else if (pend_left) begin
         kind = KIND_LEFT;
      end else begin
         kind = KIND_FINAL;
      end
   end

   always_comb begin
      self_px  = px;
      has_nb   = '0;
      nb_px    = '0;
      is_last  = 1'b1;
      done_set = 2'b00;
      unique case (kind)
         KIND_ABOVE: begin
            self_px  = pa;
            has_nb   = {head_flags.has_right, 1'b1, head_flags.col_ge1, head_flags.row_ge2};
            nb_px    = {pb, px, pul, pu};
            is_last  = !(head_flags.has_left || head_flags.has_final);
            done_set = 2'b01;
         end
         KIND_LEFT: begin
            self_px  = pml;
            has_nb   = {1'b1, 1'b0, head_flags.col_ge2, head_flags.has_above};
            nb_px    = {px, {PB{1'b0}}, pmll, pul};
            is_last  = !head_flags.has_final;
            done_set = 2'b10;
         end
         KIND_FINAL: begin
            self_px  = px;
            has_nb   = {1'b0, 1'b0, head_flags.col_ge1, head_flags.has_above};
            nb_px    = {{PB{1'b0}}, {PB{1'b0}}, pml, pa};
            is_last  = 1'b1;
            done_set = 2'b00;
         end
         default: ;
      endcase
   end

   assign clipped = clip_peak(self_px, has_nb, nb_px);
   assign load    = head_valid && (!out_valid_ff || pop);
   assign q_pop   = load && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
            done_ff      <= is_last ? 2'b00 : (done_ff | done_set);
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= PIXEL_PORT_W'(clipped);
         last_ff  <= is_last;
         eof_ff   <= (kind == KIND_FINAL);
      end
   end

   assign empty        = !out_valid_ff;
   assign pixel_out    = pixel_ff;
   assign last_in_run  = last_ff;
   assign end_of_frame = eof_ff;

endmodule

// File: rtl/four_neighbour_peak_clip.sv
// ----------------------------------------------------------------------------
// four_neighbour_peak_clip: local peak clipping over the four-neighbourhood
// A request is registered in the front end and queued before its first result is
// loaded into the output register; further results follow one per cycle while popped.
// Throughput: one request per cycle while full is low; on the last row of a taller frame
// the single sequencer gives up to two results per request (three for the final pixel).
// Reset (synchronous): clears position, queue and output; line store untouched.
// ----------------------------------------------------------------------------
module four_neighbour_peak_clip
   import fnpc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 16
)
(
   input  logic                    clock,
   input  logic                    reset,
   // request side
   input  logic                    push,
   output logic                    full,
   input  logic [PIXEL_PORT_W-1:0] req_pixel_in,
   // result side
   output logic                    empty,
   input  logic                    pop,
   output logic [PIXEL_PORT_W-1:0] rsp_pixel_out,
   output logic                    rsp_last_in_run,
   output logic                    rsp_end_of_frame,
   // configuration
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   // The queue carries the classification flags of a request together with
   // the seven pixels that its results may need.
   localparam int PIX_W = SLOT_COUNT * PIXEL_BITS;
   localparam int QW    = $bits(fnpc_flags_type) + PIX_W;

   fnpc_cfg_type            cfg;
   logic                    q_push, q_pop, q_head_valid;
   fnpc_flags_type          q_flags;
   logic [PIX_W-1:0]        q_pix;
   logic [QW-1:0]           q_head;
   logic [QCOUNT_W-1:0]     q_count;
   fnpc_flags_type          head_flags;
   logic [PIX_W-1:0]        head_pix;

   // The configuration registers. Any write restarts the frame, so the
   // counters return to the top-left corner at the same clock edge.
   fnpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The front end accepts a request, works out where it sits in the frame,
   // reads the two stored rows and decides which results it releases. It
   // holds off new requests while the queue could not take them.
   fnpc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .full     (full),
      .pixel_in (req_pixel_in),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_flags  (q_flags),
      .q_pix    (q_pix)
   );

   // The queue lets the front end keep taking requests while the back end
   // works through a request that releases more than one result.
   fnpc_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (q_push),
      .wr_data    ({q_flags, q_pix}),
      .rd_en      (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head),
      .count      (q_count)
   );

   assign head_flags = fnpc_flags_type'(q_head[QW-1:PIX_W]);
   assign head_pix   = q_head[PIX_W-1:0];

   // The back end gives one result per cycle into its output register while the queue is
   // not empty; the register is loaded again in the same cycle as its content is taken.
   fnpc_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (q_head_valid),
      .head_flags   (head_flags),
      .head_pix     (head_pix),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .pixel_out    (rsp_pixel_out),
      .last_in_run  (rsp_last_in_run),
      .end_of_frame (rsp_end_of_frame)
   );

endmodule
